// ----- rtl/array_deque_indexed_store_unit_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the array deque indexed store unit
// Concurrent checks that compile away when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef ARRAY_DEQUE_INDEXED_STORE_UNIT_MACROS_SVH
`define ARRAY_DEQUE_INDEXED_STORE_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// Check an expression at every clock edge outside reset.
`define ADSU_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error(msg);

// Check that a condition implies a consequence in the next cycle.
`define ADSU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ADSU_ASSERT_ALWAYS(lbl, expr, msg)
`define ADSU_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ----- rtl/adsu_pkg.sv -----
// ---------------------------------------------------------------------------
// adsu_pkg
// Command and status codes of the array deque indexed store unit.
// ---------------------------------------------------------------------------
`default_nettype none

package adsu_pkg;

    localparam int KIND_W   = 3;
    localparam int STATUS_W = 2;

    typedef logic [KIND_W-1:0]   t_kind;
    typedef logic [STATUS_W-1:0] t_status;

    localparam t_kind KIND_INSERT = 3'd0;
    localparam t_kind KIND_REMOVE = 3'd1;
    localparam t_kind KIND_GET    = 3'd2;
    localparam t_kind KIND_SET    = 3'd3;
    localparam t_kind KIND_FIND   = 3'd4;
    localparam t_kind KIND_CLEAR  = 3'd5;

    localparam t_status ST_OK       = 2'd0;
    localparam t_status ST_RANGE    = 2'd1;
    localparam t_status ST_FULL     = 2'd2;
    localparam t_status ST_NOTFOUND = 2'd3;

endpackage

`default_nettype wire

// ----- rtl/array_deque_indexed_store_unit.sv -----
// Array deque indexed store unit. Holds up to CAPACITY words in a circular
// single-port-write, single-port-read memory with a head slot and a count,
// and runs one command per transaction: insert, remove, get, set, find or
// clear at a logical position. One command is worked on at a time; the
// input side stalls until its result is registered, and the next command is
// taken while that result still waits downstream. Steps per command: clear,
// unused codes, an insert, remove, get or set out of range and an insert into
// a full store go straight to the result; get reads its word and set writes
// its slot; insert moves m words and then writes the new one; remove reads
// its word and then moves m words. The m words move one per cycle through the
// memory's read and write ports: m is the position when it lies below half
// the count (front side), else count - position for insert and count -
// position - 1 for remove, so at most CAPACITY/2 moves; find reads the
// elements in order and stops at the first match or after the last one, one
// compare per cycle against the registered read data. A result that waits on
// a stalled output register holds the next command in its final state. No
// clearing pass is needed after reset: only written entries are ever read.
// ---------------------------------------------------------------------------
// array_deque_indexed_store_unit
// Circular-buffer deque with positional insert/remove, get, set and find.
// ---------------------------------------------------------------------------
`default_nettype none

`include "array_deque_indexed_store_unit_macros.svh"

module array_deque_indexed_store_unit
    import adsu_pkg::*;
#(
    parameter int CAPACITY   = 16,
    parameter int DATA_WIDTH = 32
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    // command channel
    input  wire                             i_valid,
    output logic                            o_stall,
    input  wire  [KIND_W-1:0]               i_kind,
    input  wire  [$clog2(CAPACITY+1)-1:0]   i_position,
    input  wire  [DATA_WIDTH-1:0]           i_value,
    // result channel
    output logic                            o_valid,
    input  wire                             i_stall,
    output logic [STATUS_W-1:0]             o_status,
    output logic [DATA_WIDTH-1:0]           o_read_value,
    output logic [$clog2(CAPACITY)-1:0]     o_found_position,
    output logic [$clog2(CAPACITY+1)-1:0]   o_count_after
);

    // slot index width and count width
    localparam int SW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY+1);

    localparam logic [CW:0]   CAP_SUM   = (CW+1)'(CAPACITY);
    localparam logic [CW-1:0] CAP_COUNT = CW'(CAPACITY);
    localparam logic [SW-1:0] LAST_SLOT = SW'(CAPACITY - 1);
    localparam logic [CW-1:0] ONE_COUNT = CW'(1);

    // controller states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_GRAB = 3'd1;
    localparam logic [2:0] S_MOVE = 3'd2;
    localparam logic [2:0] S_FIND = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    // physical slot of a logical offset from a base slot
    function automatic logic [SW-1:0] slot_add(input logic [SW-1:0] base,
                                               input logic [CW-1:0] off);
        logic [CW:0] sum;
        sum = {{(CW+1-SW){1'b0}}, base} + {1'b0, off};
        if (sum >= CAP_SUM) begin
            sum = sum - CAP_SUM;
        end
        return sum[SW-1:0];
    endfunction

    // neighbor slot, wrapping around the ring
    function automatic logic [SW-1:0] slot_step(input logic [SW-1:0] s,
                                                input logic        up);
        logic [SW-1:0] r;
        if (up) begin
            r = (s == LAST_SLOT) ? '0 : s + SW'(1);
        end else begin
            r = (s == '0) ? LAST_SLOT : s - SW'(1);
        end
        return r;
    endfunction

    // -----------------------------------------------------------------------
    // Storage: one write port, one read port with registered data
    // -----------------------------------------------------------------------
    logic [DATA_WIDTH-1:0] r_mem [CAPACITY];
    logic [DATA_WIDTH-1:0] r_rdata;

    logic                  mem_we;
    logic [SW-1:0]         mem_waddr;
    logic [DATA_WIDTH-1:0] mem_wdata;
    logic                  mem_re;
    logic [SW-1:0]         mem_raddr;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= r_mem[mem_raddr];
        end
    end

    // -----------------------------------------------------------------------
    // Controller registers
    // -----------------------------------------------------------------------
    logic [2:0]            r_state;
    logic [SW-1:0]         r_head;      // slot of logical element 0
    logic [CW-1:0]         r_count;     // elements held
    t_kind                 r_kind;      // command in flight
    logic [DATA_WIDTH-1:0] r_word;      // word to write or search for
    logic [SW-1:0]         r_fslot;     // slot of the final write
    logic                  r_front;     // remove shifts the front side

    // shift engine: dst takes the word at src, src steps on
    logic [SW-1:0]         r_dst;
    logic [SW-1:0]         r_src;
    logic                  r_up;
    logic [CW-1:0]         r_left;
    logic                  r_pend;      // a read is in flight, write it next
    logic [SW-1:0]         r_pdst;

    // find scan
    logic [CW-1:0]         r_issue;     // next logical index to read
    logic                  r_cv;        // r_rdata holds element r_cidx
    logic [SW-1:0]         r_cidx;

    // result being built
    t_status               r_status;
    logic [DATA_WIDTH-1:0] r_rd;
    logic [SW-1:0]         r_found;

    // output register
    logic                  r_ovalid;
    t_status               r_ostatus;
    logic [DATA_WIDTH-1:0] r_oread;
    logic [SW-1:0]         r_ofound;
    logic [CW-1:0]         r_ocount;

    logic          accept;
    logic [CW-1:0] half;
    logic          in_range;    // position names an element
    logic          find_hit;
    logic          find_issue;
    logic          out_load;    // finished result moves into the output register

    assign o_stall  = (r_state != S_IDLE);
    assign accept   = i_valid && (r_state == S_IDLE);
    assign half     = r_count >> 1;
    assign in_range = (i_position < r_count);
    assign find_hit = r_cv && (r_rdata == r_word);
    assign find_issue = !find_hit && (r_issue != r_count);
    assign out_load = (r_state == S_DONE) && (!r_ovalid || !i_stall);

    // -----------------------------------------------------------------------
    // Memory port steering
    // -----------------------------------------------------------------------
    always_comb begin
        mem_re    = 1'b0;
        mem_raddr = r_src;
        mem_we    = 1'b0;
        mem_waddr = r_pdst;
        mem_wdata = r_rdata;
        case (r_state)
            S_IDLE: begin
                // fetch the addressed word for get and remove
                if (accept && in_range
                        && ((i_kind == KIND_GET) || (i_kind == KIND_REMOVE))) begin
                    mem_re    = 1'b1;
                    mem_raddr = slot_add(r_head, i_position);
                end
            end
            S_MOVE: begin
                mem_re = (r_left != '0);
                mem_we = r_pend;
            end
            S_FIND: begin
                mem_re = find_issue;
            end
            S_FIN: begin
                if ((r_kind == KIND_INSERT) || (r_kind == KIND_SET)) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_fslot;
                    mem_wdata = r_word;
                end
            end
            default: begin
            end
        endcase
    end

    // -----------------------------------------------------------------------
    // Sequencer
    // -----------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_head   <= '0;
            r_count  <= '0;
            r_pend   <= 1'b0;
            r_cv     <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            // raise valid on a new result, drop it once downstream takes it
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && !i_stall) begin
                r_ovalid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_kind   <= i_kind;
                        r_word   <= i_value;
                        r_rd     <= '0;
                        r_found  <= '0;
                        r_pend   <= 1'b0;
                        r_cv     <= 1'b0;
                        case (i_kind)
                            KIND_INSERT: begin
                                if (i_position > r_count) begin
                                    r_status <= ST_RANGE;
                                    r_state  <= S_DONE;
                                end else if (r_count == CAP_COUNT) begin
                                    r_status <= ST_FULL;
                                    r_state  <= S_DONE;
                                end else if (i_position < half) begin
                                    // open a gap at the front: head moves back,
                                    // elements before the position shift down
                                    r_status <= ST_OK;
                                    r_head  <= slot_step(r_head, 1'b0);
                                    r_dst   <= slot_step(r_head, 1'b0);
                                    r_src   <= r_head;
                                    r_up    <= 1'b1;
                                    r_left  <= i_position;
                                    r_fslot <= slot_add(slot_step(r_head, 1'b0),
                                                        i_position);
                                    r_state <= S_MOVE;
                                end else begin
                                    // open a gap at the back
                                    r_status <= ST_OK;
                                    r_dst   <= slot_add(r_head, r_count);
                                    r_src   <= slot_step(slot_add(r_head, r_count), 1'b0);
                                    r_up    <= 1'b0;
                                    r_left  <= r_count - i_position;
                                    r_fslot <= slot_add(r_head, i_position);
                                    r_state <= S_MOVE;
                                end
                            end
                            KIND_REMOVE: begin
                                if (!in_range) begin
                                    r_status <= ST_RANGE;
                                    r_state  <= S_DONE;
                                end else begin
                                    r_status <= ST_OK;
                                    r_dst   <= slot_add(r_head, i_position);
                                    r_front <= (i_position < half);
                                    if (i_position < half) begin
                                        // close the hole from the front
                                        r_src  <= slot_step(slot_add(r_head, i_position),
                                                            1'b0);
                                        r_up   <= 1'b0;
                                        r_left <= i_position;
                                    end else begin
                                        // close the hole from the back
                                        r_src  <= slot_step(slot_add(r_head, i_position),
                                                            1'b1);
                                        r_up   <= 1'b1;
                                        r_left <= r_count - i_position - ONE_COUNT;
                                    end
                                    r_state <= S_GRAB;
                                end
                            end
                            KIND_GET: begin
                                if (!in_range) begin
                                    r_status <= ST_RANGE;
                                    r_state  <= S_DONE;
                                end else begin
                                    r_status <= ST_OK;
                                    r_state  <= S_GRAB;
                                end
                            end
                            KIND_SET: begin
                                if (!in_range) begin
                                    r_status <= ST_RANGE;
                                    r_state  <= S_DONE;
                                end else begin
                                    r_status <= ST_OK;
                                    r_fslot  <= slot_add(r_head, i_position);
                                    r_state  <= S_FIN;
                                end
                            end
                            KIND_FIND: begin
                                r_status <= ST_NOTFOUND;
                                r_src    <= r_head;
                                r_issue  <= '0;
                                r_state  <= S_FIND;
                            end
                            KIND_CLEAR: begin
                                r_status <= ST_OK;
                                r_count  <= '0;
                                r_head   <= '0;
                                r_state  <= S_DONE;
                            end
                            default: begin
                                // unused codes: report ok, change nothing
                                r_status <= ST_OK;
                                r_state  <= S_DONE;
                            end
                        endcase
                    end
                end

                S_GRAB: begin
                    // hold the word read for get or remove
                    r_rd    <= r_rdata;
                    r_state <= (r_kind == KIND_GET) ? S_DONE : S_MOVE;
                end

                S_MOVE: begin
                    // one move per cycle: read src now, write its old dst next
                    if (r_left != '0) begin
                        r_pdst <= r_dst;
                        r_pend <= 1'b1;
                        r_dst  <= r_src;
                        r_src  <= slot_step(r_src, r_up);
                        r_left <= r_left - ONE_COUNT;
                    end else begin
                        r_pend  <= 1'b0;
                        r_state <= S_FIN;
                    end
                end

                S_FIND: begin
                    if (find_hit) begin
                        r_status <= ST_OK;
                        r_found  <= r_cidx;
                        r_state  <= S_DONE;
                    end else if (r_issue == r_count) begin
                        r_state <= S_DONE;
                    end else begin
                        r_src   <= slot_step(r_src, 1'b1);
                        r_cidx  <= r_issue[SW-1:0];
                        r_issue <= r_issue + ONE_COUNT;
                        r_cv    <= 1'b1;
                    end
                end

                S_FIN: begin
                    case (r_kind)
                        KIND_INSERT: begin
                            r_count <= r_count + ONE_COUNT;
                        end
                        KIND_REMOVE: begin
                            r_count <= r_count - ONE_COUNT;
                            if (r_front) begin
                                r_head <= slot_step(r_head, 1'b1);
                            end
                        end
                        default: begin
                        end
                    endcase
                    r_state <= S_DONE;
                end

                S_DONE: begin
                    // load the result once the output register is free
                    if (out_load) begin
                        r_ostatus <= r_status;
                        r_oread   <= r_rd;
                        r_ofound  <= r_found;
                        r_ocount  <= r_count;
                        r_state   <= S_IDLE;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid          = r_ovalid;
    assign o_status         = r_ostatus;
    assign o_read_value     = r_oread;
    assign o_found_position = r_ofound;
    assign o_count_after    = r_ocount;

    // -----------------------------------------------------------------------
    // Assertions
    // -----------------------------------------------------------------------
    `ADSU_ASSERT_ALWAYS(a_count_bound, r_count <= CAP_COUNT, "count above capacity")
    `ADSU_ASSERT_ALWAYS(a_rw_apart, !(mem_we && mem_re) || (mem_waddr != mem_raddr),
        "read and write hit the same slot")
    `ADSU_ASSERT_ALWAYS(a_moves_bound, (r_state != S_MOVE) || (r_left <= r_count),
        "more moves pending than elements")
    `ADSU_ASSERT_NEXT(a_insert_grows, (r_state == S_FIN) && (r_kind == KIND_INSERT),
        r_count == $past(r_count) + ONE_COUNT, "insert did not grow the count")
    `ADSU_ASSERT_NEXT(a_result_loaded, (r_state == S_DONE) && (!r_ovalid || !i_stall),
        o_valid && (r_state == S_IDLE), "result not loaded on completion")

endmodule

`default_nettype wire
